>>> hw/rtl/h264_rtp_fragment_reassembly_control_core_assert.svh
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer control - assertion macros
// Concurrent checks on the core's clock; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef H264_RTP_FRAGMENT_REASSEMBLY_CONTROL_CORE_ASSERT_SVH
`define H264_RTP_FRAGMENT_REASSEMBLY_CONTROL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check outside reset
`define H264RFR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("h264rfr assertion failed");
// check at every edge, reset included
`define H264RFR_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("h264rfr reset assertion failed");
`else
`define H264RFR_ASSERT(label, prop)
`define H264RFR_ASSERT_RST(label, prop)
`endif

`endif

>>> hw/rtl/h264rfr_pkg.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer control - package
// Request/result payload types, state types, codes and constants.
// ----------------------------------------------------------------------------
package h264rfr_pkg;

    localparam logic [4:0]  NAL_TYPE_FU_A   = 5'd28;
    localparam logic [4:0]  NAL_TYPE_LIMIT  = 5'd24;
    localparam logic [4:0]  NAL_TYPE_SPS    = 5'd7;
    localparam logic [4:0]  NAL_TYPE_PPS    = 5'd8;
    localparam int unsigned FU_START_BIT    = 7;
    localparam int unsigned FU_END_BIT      = 6;
    localparam logic [7:0]  NAL_NRI_MASK    = 8'hE0;
    localparam logic [15:0] SEQ_MAX         = 16'hFFFF;
    localparam logic [1:0]  SKIP_FU         = 2'd2;
    localparam logic [1:0]  SKIP_NONE       = 2'd0;

    localparam logic [14:0] MAX_SEQ_GAP_RST = 15'd100;
    localparam logic [10:0] MAX_FRAG_RST    = 11'd1024;

    localparam logic        CFG_IDX_SEQ_GAP  = 1'b0;
    localparam logic        CFG_IDX_MAX_FRAG = 1'b1;

    localparam logic [1:0]  PS_OTHER = 2'd0;
    localparam logic [1:0]  PS_SPS   = 2'd1;
    localparam logic [1:0]  PS_PPS   = 2'd2;

    typedef enum logic [3:0] {
        DISP_IGNORED     = 4'd0,
        DISP_SINGLE      = 4'd1,
        DISP_RUN_START   = 4'd2,
        DISP_FRAGMENT    = 4'd3,
        DISP_COMMITTED   = 4'd4,
        DISP_INCOMPLETE  = 4'd5,
        DISP_ABORTED     = 4'd6,
        DISP_STALE       = 4'd7,
        DISP_UNSUPPORTED = 4'd8
    } t_disp;

    typedef struct packed {
        logic [15:0] sequence_req;
        logic        marker;
        logic [15:0] payload_length;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
    } t_in_req;

    typedef struct packed {
        t_disp       disposition;
        logic [7:0]  nal_header;
        logic [1:0]  skip_bytes;
        logic        frame_discarded;
        logic        frame_ready;
        logic [1:0]  parameter_set;
        logic [10:0] unit_fragments;
    } t_out_rsp;

    typedef struct packed {
        logic        active;
        logic [15:0] next_seq;
        logic        broken;
        logic [10:0] count;
    } t_run;

    typedef struct packed {
        logic [15:0] last_seq;
        t_run        run;
        logic        frame_has_data;
    } t_state;

    typedef struct packed {
        logic [14:0] max_seq_gap;
        logic [10:0] max_fragments;
    } t_cfg;

    function automatic logic [1:0] ps_kind(input logic [4:0] nal_type);
        logic [1:0] kind;
        kind = PS_OTHER;
        if (nal_type == NAL_TYPE_SPS) kind = PS_SPS;
        else if (nal_type == NAL_TYPE_PPS) kind = PS_PPS;
        return kind;
    endfunction

endpackage

>>> hw/rtl/h264rfr_state.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer control - state and configuration registers
// Holds sequence/run/frame state and the two config registers.
// ----------------------------------------------------------------------------
module h264rfr_state (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [14:0]          i_cfg_data,
    input  logic                 i_advance,
    input  h264rfr_pkg::t_state  i_next,
    output h264rfr_pkg::t_state  o_state,
    output h264rfr_pkg::t_cfg    o_cfg
);
    import h264rfr_pkg::*;

    t_state r_state;
    t_cfg   r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_advance) begin
            r_state <= i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_seq_gap   <= MAX_SEQ_GAP_RST;
            r_cfg.max_fragments <= MAX_FRAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_SEQ_GAP:  r_cfg.max_seq_gap   <= i_cfg_data;
                CFG_IDX_MAX_FRAG: r_cfg.max_fragments <= i_cfg_data[10:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_state = r_state;
    assign o_cfg   = r_cfg;

endmodule

>>> hw/rtl/h264rfr_decide.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer control - packet decision
// Classifies one packet header and computes result and next state.
// ----------------------------------------------------------------------------
module h264rfr_decide (
    input  h264rfr_pkg::t_in_req  i_req,
    input  h264rfr_pkg::t_state   i_state,
    input  h264rfr_pkg::t_cfg     i_cfg,
    output h264rfr_pkg::t_state   o_next,
    output h264rfr_pkg::t_out_rsp o_rsp
);
    import h264rfr_pkg::*;

    logic [15:0] seq;
    logic [15:0] last;
    logic [15:0] gap_ext;
    logic [15:0] wrap_lim;
    logic [15:0] seq_dist;
    logic [15:0] run_dist;
    logic [4:0]  nal_type;
    logic [4:0]  fu_type;
    logic [7:0]  rebuilt;
    logic [11:0] cnt_inc;
    logic        seen;
    logic        dup;
    logic        broken_new;
    logic        check;
    t_state      nst;
    t_out_rsp    rsp;

    assign seq      = i_req.sequence_req;
    assign last     = i_state.last_seq;
    assign gap_ext  = {1'b0, i_cfg.max_seq_gap};
    assign wrap_lim = SEQ_MAX - gap_ext;
    assign seen     = (last != '0);
    // forward distance mod 2^16
    assign seq_dist = seq - last;
    assign nal_type = i_req.first_byte[4:0];
    assign fu_type  = i_req.second_byte[4:0];
    assign rebuilt  = (i_req.first_byte & NAL_NRI_MASK) | {3'b000, fu_type};
    // a low sequence after a high last one is a wrap, not a duplicate
    assign dup      = seen && (seq <= last) && !((last > wrap_lim) && (seq < gap_ext));

    always_comb begin
        nst        = i_state;
        rsp        = '0;
        rsp.disposition = DISP_IGNORED;
        check      = 1'b0;
        run_dist   = '0;
        cnt_inc    = '0;
        broken_new = 1'b0;
        priority if (i_req.payload_length == '0) begin
            nst = i_state;
        end else if (dup) begin
            rsp.disposition = DISP_STALE;
        end else begin
            if (seen && (seq_dist > gap_ext)) begin
                nst.run            = '0;
                nst.frame_has_data = 1'b0;
                rsp.frame_discarded = 1'b1;
            end
            run_dist   = seq - nst.run.next_seq;
            cnt_inc    = {1'b0, nst.run.count} + 12'd1;
            broken_new = nst.run.broken || (seq != nst.run.next_seq) ||
                         (nst.run.next_seq == '0);

            priority if ((nal_type != '0) && (nal_type < NAL_TYPE_LIMIT)) begin
                nst.run            = '0;
                rsp.disposition    = DISP_SINGLE;
                rsp.nal_header     = i_req.first_byte;
                rsp.parameter_set  = ps_kind(nal_type);
                nst.frame_has_data = 1'b1;
                check              = 1'b1;
            end else if (nal_type == NAL_TYPE_FU_A) begin
                priority if ((i_req.payload_length < 16'd2) || (fu_type == '0) ||
                             (fu_type >= NAL_TYPE_LIMIT)) begin
                    nst.run         = '0;
                    rsp.disposition = DISP_ABORTED;
                end else if (i_req.second_byte[FU_START_BIT]) begin
                    nst.run = '0;
                    priority if (i_req.payload_length == 16'd2) begin
                        rsp.disposition = DISP_ABORTED;
                    end else if (i_cfg.max_fragments == '0) begin
                        rsp.disposition = DISP_ABORTED;
                        check           = 1'b1;
                    end else begin
                        nst.run.active   = 1'b1;
                        nst.run.next_seq = seq + 16'd1;
                        nst.run.count    = 11'd1;
                        rsp.disposition  = DISP_RUN_START;
                        rsp.nal_header   = rebuilt;
                        rsp.skip_bytes   = SKIP_FU;
                        check            = 1'b1;
                    end
                end else if (nst.run.active) begin
                    priority if (seq < nst.run.next_seq) begin
                        rsp.disposition = DISP_STALE;
                    end else if (run_dist > gap_ext) begin
                        nst.run         = '0;
                        rsp.disposition = DISP_ABORTED;
                    end else if (cnt_inc > {1'b0, i_cfg.max_fragments}) begin
                        nst.run         = '0;
                        rsp.disposition = DISP_ABORTED;
                    end else begin
                        nst.run.broken   = broken_new;
                        nst.run.count    = cnt_inc[10:0];
                        nst.run.next_seq = seq + 16'd1;
                        rsp.nal_header   = rebuilt;
                        rsp.skip_bytes   = SKIP_FU;
                        check            = 1'b1;
                        if (i_req.second_byte[FU_END_BIT]) begin
                            // wrap inside the run leaves it incomplete
                            if (!broken_new && (seq != SEQ_MAX)) begin
                                nst.frame_has_data = 1'b1;
                                rsp.parameter_set  = ps_kind(fu_type);
                                rsp.disposition    = DISP_COMMITTED;
                            end else begin
                                rsp.disposition = DISP_INCOMPLETE;
                            end
                            nst.run = '0;
                        end else begin
                            rsp.disposition = DISP_FRAGMENT;
                        end
                    end
                end else begin
                    rsp.disposition = DISP_IGNORED;
                    check           = 1'b1;
                end
            end else begin
                rsp.disposition = DISP_UNSUPPORTED;
                check           = 1'b1;
            end

            if (check && i_req.marker && nst.frame_has_data) begin
                rsp.frame_ready    = 1'b1;
                nst.frame_has_data = 1'b0;
            end
            nst.last_seq = seq;
        end
        rsp.unit_fragments = nst.run.count;
    end

    assign o_next = nst;
    assign o_rsp  = rsp;

endmodule

>>> hw/rtl/h264_rtp_fragment_reassembly_control_core.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer control - top level
// Per-packet disposition for single NAL units and FU-A fragment runs.
//
//   channel   dir   handshake                     payload
//   in        in    i_in_valid / o_in_stall       i_in_data  (t_in_req)
//   out       out   o_out_valid / i_out_stall     o_out_data (t_out_rsp)
//   cfg       in    i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while i_out_stall is low; a request passes
// the request register, then the decision into the result register. State
// updates as the request leaves the request register. A stalled result holds
// the request register; a new request is still taken while the result
// register is free or drains. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`include "h264_rtp_fragment_reassembly_control_core_assert.svh"

module h264_rtp_fragment_reassembly_control_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  h264rfr_pkg::t_in_req   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output h264rfr_pkg::t_out_rsp  o_out_data,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [14:0]            i_cfg_data
);
    import h264rfr_pkg::*;

    logic     r_in_valid;
    t_in_req  r_in;
    logic     r_out_valid;
    t_out_rsp r_out;
    logic     advance;
    logic     in_take;
    t_state   state;
    t_state   next_state;
    t_cfg     cfg;
    t_out_rsp rsp;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    h264rfr_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_next     (next_state),
        .o_state    (state),
        .o_cfg      (cfg)
    );

    h264rfr_decide u_decide (
        .i_req   (r_in),
        .i_state (state),
        .i_cfg   (cfg),
        .o_next  (next_state),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an active run always holds at least one fragment, an idle one none
    `H264RFR_ASSERT(a_run_count_active, (state.run.active == (state.run.count != '0)))
    // stale or duplicate packets never close a frame
    `H264RFR_ASSERT(a_stale_not_ready, (o_out_valid && o_out_data.frame_ready) |-> (o_out_data.disposition != DISP_STALE))
    // payload skip only for fragments that are written
    `H264RFR_ASSERT(a_skip_matches_disp, (o_out_valid && (o_out_data.skip_bytes == SKIP_FU)) |-> (o_out_data.disposition == DISP_RUN_START || o_out_data.disposition == DISP_FRAGMENT || o_out_data.disposition == DISP_COMMITTED || o_out_data.disposition == DISP_INCOMPLETE))
    // no result right after reset
    `H264RFR_ASSERT_RST(a_reset_no_result, !i_rst_n |=> !o_out_valid)

endmodule
